>>> rtl/mrmsa_pkg.sv
// ============================================================================
// mrmsa_pkg
// Shared types and constants for the mouse report multi-slot accumulator:
// field widths, stream word layout, operation codes, register indexes and
// the sequencer state encoding.
// ============================================================================
package mrmsa_pkg;

    // Default number of consumer slots
    localparam int SLOT_COUNT_DEF = 8;

    // Field widths
    localparam int SLOT_FIELD_W = 3;
    localparam int MODE_W       = 3;
    localparam int RAW_W        = 17;
    localparam int ABS_W        = 18;
    localparam int DELTA_W      = 19;
    localparam int EXT_W        = 16;
    localparam int FLAGS_W      = 16;
    localparam int WHEEL_W      = 16;
    localparam int SUM_W        = 32;
    localparam int BTN_W        = 5;
    localparam int KIND_W       = 2;
    localparam int PROD_W       = RAW_W + EXT_W + 1;
    localparam int MAG_W        = PROD_W - 1;

    // Absolute scale: round(raw * extent / FULL_SCALE)
    localparam int FULL_SCALE   = 65535;
    localparam int HALF_SCALE   = FULL_SCALE / 2;

    // Button flag layout
    localparam int WHEEL_BIT    = 10;

    // Stream word widths
    localparam int S_TDATA_W    = 72;
    localparam int S_TUSER_W    = 5;
    localparam int M_TDATA_W    = 104;
    localparam int M_TUSER_W    = KIND_W;

    // Configuration port
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = EXT_W;

    localparam logic [EXT_W-1:0] SCREEN_W_RST = 16'd1920;
    localparam logic [EXT_W-1:0] SCREEN_H_RST = 16'd1080;
    localparam logic [EXT_W-1:0] VIRT_W_RST   = 16'd1920;
    localparam logic [EXT_W-1:0] VIRT_H_RST   = 16'd1080;

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SCREEN_W = 2'd0,
        CFG_SCREEN_H = 2'd1,
        CFG_VIRT_W   = 2'd2,
        CFG_VIRT_H   = 2'd3
    } cfg_index_t;

    // Operation codes
    typedef enum logic [MODE_W-1:0] {
        MODE_REPORT  = 3'd0,
        MODE_ACQUIRE = 3'd1,
        MODE_RELEASE = 3'd2,
        MODE_TAKE    = 3'd3,
        MODE_RESET   = 3'd4
    } mode_t;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACQUIRED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ABS,
        ST_DIV,
        ST_DELTA,
        ST_WALK,
        ST_SEARCH,
        ST_EXEC,
        ST_RESULT
    } state_t;

    // Scale unit strobes
    typedef struct packed {
        logic mul_en;
        logic abs_en;
    } scale_ctl_t;

endpackage

>>> rtl/mrmsa_scale.sv
// ============================================================================
// mrmsa_scale
// Absolute position scaler: round(raw * extent / 65535), halves away from
// zero. Product and rounded magnitude are registered; the division by
// 65535 is two end-around folds of the 16-bit halves.
// ============================================================================
module mrmsa_scale (
    input  logic                                  aclk,
    input  mrmsa_pkg::scale_ctl_t                 ctl,
    input  logic signed [mrmsa_pkg::RAW_W-1:0]    raw,
    input  logic        [mrmsa_pkg::EXT_W-1:0]    extent,
    output logic signed [mrmsa_pkg::ABS_W-1:0]    scaled
);
    import mrmsa_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic        [MAG_W-1:0]  mag;
    logic        [MAG_W-1:0]  v_reg;
    logic                     neg_reg;
    logic        [RAW_W-1:0]  q0;
    logic        [RAW_W:0]    t;
    logic        [RAW_W-1:0]  u;
    logic        [RAW_W-1:0]  q;

    // Stage 1: signed product
    always_ff @(posedge aclk) begin
        if (ctl.mul_en) begin
            prod_reg <= PROD_W'(raw) * PROD_W'($signed({1'b0, extent}));
        end
    end

    // Stage 2: magnitude plus half for rounding
    assign mag = prod_reg[PROD_W-1] ? MAG_W'(-prod_reg) : MAG_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (ctl.abs_en) begin
            neg_reg <= prod_reg[PROD_W-1];
            v_reg   <= mag + MAG_W'(HALF_SCALE);
        end
    end

    // v = q0*65535 + t, t = t1*65535 + u, u < 2*65535
    assign q0 = v_reg[MAG_W-1:16];
    assign t  = {1'b0, q0} + {2'b00, v_reg[15:0]};
    assign u  = {15'd0, t[RAW_W:16]} + {1'b0, t[15:0]};
    assign q  = q0 + {15'd0, t[RAW_W:16]} + {16'd0, (u >= RAW_W'(FULL_SCALE))};

    assign scaled = neg_reg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

>>> rtl/mouse_report_multi_slot_accumulator_unit.sv
// ============================================================================
// mouse_report_multi_slot_accumulator_unit
// Mouse report fan-out to consumer slots. Reports are scaled (absolute) or
// passed (relative), then added slot by slot to every active slot by one
// shared accumulate path. Acquire, release, reset and take act on slots.
//
//   channel   direction  handshake            contents
//   s_        in         s_tvalid / s_tready  report or slot operation word
//   m_        out        m_tvalid / m_tready  sample or acquire result word
//   cfg_      in         cfg_valid/cfg_ready  extent register write
//
// Absolute reports make two passes through the one multiplier and fold unit,
// then the slot walk; relative reports go straight to the slot walk.
// Acquire searches the slots for a free one; take, release and reset act on
// the named slot. One word in flight; s_tready is high only between words.
// A result waits in the output register while the next word is taken; a
// second result stalls the sequencer until m_tready. Reset is synchronous
// and clears all slot state at once; no clearing pass.
// ============================================================================
module mouse_report_multi_slot_accumulator_unit #(
    parameter int SLOT_COUNT = mrmsa_pkg::SLOT_COUNT_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // slot[2:0], raw_x[19:3], raw_y[36:20], button_flags[52:37],
    // button_data[68:53], in_focus[69], zero[71:70]
    input  logic [mrmsa_pkg::S_TDATA_W-1:0]        s_tdata,
    // mode[2:0], is_absolute[3], use_virtual_desktop[4]
    input  logic [mrmsa_pkg::S_TUSER_W-1:0]        s_tuser,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // result_slot[2:0], sum_x[34:3], sum_y[66:35], sum_wheel[98:67],
    // buttons[103:99]
    output logic [mrmsa_pkg::M_TDATA_W-1:0]        m_tdata,
    // result_kind[1:0]
    output logic [mrmsa_pkg::M_TUSER_W-1:0]        m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [mrmsa_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mrmsa_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import mrmsa_pkg::*;

    localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_IDX_W-1:0] IDX_LAST = SLOT_IDX_W'(SLOT_COUNT - 1);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    logic [EXT_W-1:0] screen_w_reg, screen_h_reg, virt_w_reg, virt_h_reg;

    mode_t                    mode_reg;
    logic [SLOT_FIELD_W-1:0]  slot_reg;
    logic                     is_abs_reg;
    logic                     virt_reg;
    logic signed [RAW_W-1:0]  raw_x_reg, raw_y_reg;
    logic [FLAGS_W-1:0]       flags_reg;
    logic [WHEEL_W-1:0]       bdata_reg;

    logic [SLOT_IDX_W-1:0]    idx_reg;
    logic                     axis_reg;
    logic                     found_reg;
    logic                     have_abs_reg;
    logic signed [ABS_W-1:0]  last_x_reg, last_y_reg;
    logic signed [ABS_W-1:0]  abs_x_reg, abs_y_reg;
    logic signed [DELTA_W-1:0] dx_reg, dy_reg;

    logic                     slot_active_reg [SLOT_COUNT];
    logic [SUM_W-1:0]         acc_x_reg       [SLOT_COUNT];
    logic [SUM_W-1:0]         acc_y_reg       [SLOT_COUNT];
    logic [SUM_W-1:0]         acc_wheel_reg   [SLOT_COUNT];
    logic [BTN_W-1:0]         held_reg        [SLOT_COUNT];
    logic [BTN_W-1:0]         latched_reg     [SLOT_COUNT];

    logic                     m_tvalid_reg;
    logic [KIND_W-1:0]        m_kind_reg;
    logic [SLOT_FIELD_W-1:0]  m_slot_reg;
    logic [SUM_W-1:0]         m_sx_reg, m_sy_reg, m_sw_reg;
    logic [BTN_W-1:0]         m_btn_reg;

    logic                     s_accept;
    mode_t                    s_mode;
    logic                     s_focus;
    logic                     s_abs;
    logic                     slot_ok;
    logic [SLOT_IDX_W-1:0]    slot_idx;
    logic [SLOT_IDX_W-1:0]    acc_addr;
    logic                     idx_last;
    logic                     cur_active;
    logic                     out_free;

    scale_ctl_t               scale_ctl;
    logic signed [RAW_W-1:0]  scale_raw;
    logic [EXT_W-1:0]         scale_ext;
    logic signed [ABS_W-1:0]  scaled;

    logic                     walk_en;
    logic                     acq_hit;
    logic                     clr_sums;
    logic                     clr_active;
    logic                     out_load;
    logic                     idx_inc;

    logic [BTN_W-1:0]         btn_down, btn_up;
    logic [SUM_W-1:0]         wheel_ext;
    logic signed [DELTA_W-1:0] dx_calc, dy_calc;

    // ------------------------------------------------------------------
    // Decode
    // ------------------------------------------------------------------
    assign s_accept   = s_tvalid && s_tready;
    assign s_mode     = mode_t'(s_tuser[2:0]);
    assign s_abs      = s_tuser[3];
    assign s_focus    = s_tdata[69];
    assign slot_ok    = (32'(slot_reg) < SLOT_COUNT);
    assign slot_idx   = SLOT_IDX_W'(slot_reg);
    assign idx_last   = (idx_reg == IDX_LAST);
    assign cur_active = slot_active_reg[idx_reg];
    assign out_free   = !m_tvalid_reg || m_tready;

    assign btn_down  = {flags_reg[8], flags_reg[6], flags_reg[4], flags_reg[2], flags_reg[0]};
    assign btn_up    = {flags_reg[9], flags_reg[7], flags_reg[5], flags_reg[3], flags_reg[1]};
    assign wheel_ext = flags_reg[WHEEL_BIT] ? {{(SUM_W-WHEEL_W){bdata_reg[WHEEL_W-1]}}, bdata_reg}
                                            : '0;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_w_reg <= SCREEN_W_RST;
            screen_h_reg <= SCREEN_H_RST;
            virt_w_reg   <= VIRT_W_RST;
            virt_h_reg   <= VIRT_H_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SCREEN_W: screen_w_reg <= cfg_data;
                CFG_SCREEN_H: screen_h_reg <= cfg_data;
                CFG_VIRT_W:   virt_w_reg   <= cfg_data;
                CFG_VIRT_H:   virt_h_reg   <= cfg_data;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input word capture
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg   <= s_mode;
            is_abs_reg <= s_tuser[3];
            virt_reg   <= s_tuser[4];
            slot_reg   <= s_tdata[2:0];
            raw_x_reg  <= s_tdata[19:3];
            raw_y_reg  <= s_tdata[36:20];
            flags_reg  <= s_tdata[52:37];
            bdata_reg  <= s_tdata[68:53];
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (s_mode)
                        MODE_REPORT:  state_next = !s_focus ? ST_IDLE :
                                                   (s_abs ? ST_MUL : ST_DELTA);
                        MODE_ACQUIRE: state_next = ST_SEARCH;
                        MODE_RELEASE: state_next = ST_EXEC;
                        MODE_RESET:   state_next = ST_EXEC;
                        MODE_TAKE:    state_next = ST_RESULT;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_MUL:    state_next = ST_ABS;
            ST_ABS:    state_next = ST_DIV;
            ST_DIV:    state_next = axis_reg ? ST_DELTA : ST_MUL;
            ST_DELTA:  state_next = ST_WALK;
            ST_WALK:   state_next = idx_last ? ST_IDLE : ST_WALK;
            ST_SEARCH: state_next = (!cur_active || idx_last) ? ST_RESULT : ST_SEARCH;
            ST_EXEC:   state_next = ST_IDLE;
            ST_RESULT: state_next = out_free ? ST_IDLE : ST_RESULT;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb begin
        s_tready       = (state_reg == ST_IDLE);
        scale_ctl      = '0;
        scale_ctl.mul_en = (state_reg == ST_MUL);
        scale_ctl.abs_en = (state_reg == ST_ABS);
        acc_addr       = ((state_reg == ST_RESULT) || (state_reg == ST_EXEC)) ? slot_idx
                                                                             : idx_reg;
        walk_en        = (state_reg == ST_WALK) && cur_active;
        acq_hit        = (state_reg == ST_SEARCH) && !cur_active;
        idx_inc        = ((state_reg == ST_WALK) || (state_reg == ST_SEARCH)) &&
                         !idx_last && !acq_hit;
        out_load       = (state_reg == ST_RESULT) && out_free;
        clr_active     = (state_reg == ST_EXEC) && (mode_reg == MODE_RELEASE) && slot_ok;
        clr_sums       = acq_hit ||
                         (out_load && (mode_reg == MODE_TAKE) && slot_ok) ||
                         ((state_reg == ST_EXEC) && (mode_reg == MODE_RESET) && slot_ok);
    end

    // ------------------------------------------------------------------
    // Walk index, axis and search result
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            axis_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else if (s_accept) begin
            idx_reg   <= '0;
            axis_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            if (idx_inc) begin
                idx_reg <= idx_reg + SLOT_IDX_W'(1);
            end
            if (state_reg == ST_DIV) begin
                axis_reg <= !axis_reg;
            end
            if (acq_hit) begin
                found_reg <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared scale unit, one axis per pass
    // ------------------------------------------------------------------
    assign scale_raw = axis_reg ? raw_y_reg : raw_x_reg;
    assign scale_ext = axis_reg ? (virt_reg ? virt_h_reg : screen_h_reg)
                                : (virt_reg ? virt_w_reg : screen_w_reg);

    mrmsa_scale u_scale (
        .aclk   (aclk),
        .ctl    (scale_ctl),
        .raw    (scale_raw),
        .extent (scale_ext),
        .scaled (scaled)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DIV) begin
            if (axis_reg) begin
                abs_y_reg <= scaled;
            end else begin
                abs_x_reg <= scaled;
            end
        end
    end

    // ------------------------------------------------------------------
    // Deltas and absolute tracking
    // ------------------------------------------------------------------
    always_comb begin
        if (is_abs_reg) begin
            if (have_abs_reg) begin
                dx_calc = {abs_x_reg[ABS_W-1], abs_x_reg} - {last_x_reg[ABS_W-1], last_x_reg};
                dy_calc = {abs_y_reg[ABS_W-1], abs_y_reg} - {last_y_reg[ABS_W-1], last_y_reg};
            end else begin
                dx_calc = '0;
                dy_calc = '0;
            end
        end else begin
            dx_calc = {{(DELTA_W-RAW_W){raw_x_reg[RAW_W-1]}}, raw_x_reg};
            dy_calc = {{(DELTA_W-RAW_W){raw_y_reg[RAW_W-1]}}, raw_y_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_DELTA) begin
            dx_reg <= dx_calc;
            dy_reg <= dy_calc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_abs_reg <= 1'b0;
            last_x_reg   <= '0;
            last_y_reg   <= '0;
        end else if (state_reg == ST_DELTA) begin
            have_abs_reg <= is_abs_reg;
            if (is_abs_reg) begin
                last_x_reg <= abs_x_reg;
                last_y_reg <= abs_y_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Slot state: one slot touched per cycle at acc_addr
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_active_reg[i] <= 1'b0;
                acc_x_reg[i]       <= '0;
                acc_y_reg[i]       <= '0;
                acc_wheel_reg[i]   <= '0;
                held_reg[i]        <= '0;
                latched_reg[i]     <= '0;
            end
        end else begin
            if (walk_en) begin
                acc_x_reg[acc_addr]     <= acc_x_reg[acc_addr] +
                    {{(SUM_W-DELTA_W){dx_reg[DELTA_W-1]}}, dx_reg};
                acc_y_reg[acc_addr]     <= acc_y_reg[acc_addr] +
                    {{(SUM_W-DELTA_W){dy_reg[DELTA_W-1]}}, dy_reg};
                acc_wheel_reg[acc_addr] <= acc_wheel_reg[acc_addr] + wheel_ext;
                held_reg[acc_addr]      <= (held_reg[acc_addr] | btn_down) & ~btn_up;
                latched_reg[acc_addr]   <= latched_reg[acc_addr] | btn_down;
            end
            if (clr_sums) begin
                acc_x_reg[acc_addr]     <= '0;
                acc_y_reg[acc_addr]     <= '0;
                acc_wheel_reg[acc_addr] <= '0;
                latched_reg[acc_addr]   <= '0;
            end
            if (acq_hit) begin
                held_reg[acc_addr]        <= '0;
                slot_active_reg[acc_addr] <= 1'b1;
            end
            if (clr_active) begin
                slot_active_reg[acc_addr] <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (mode_reg == MODE_TAKE) begin
                m_kind_reg <= KIND_SAMPLE;
                m_slot_reg <= slot_reg;
                m_sx_reg   <= slot_ok ? acc_x_reg[acc_addr]     : '0;
                m_sy_reg   <= slot_ok ? acc_y_reg[acc_addr]     : '0;
                m_sw_reg   <= slot_ok ? acc_wheel_reg[acc_addr] : '0;
                m_btn_reg  <= slot_ok ? (held_reg[acc_addr] | latched_reg[acc_addr]) : '0;
            end else begin
                m_kind_reg <= found_reg ? KIND_ACQUIRED : KIND_FULL;
                m_slot_reg <= found_reg ? SLOT_FIELD_W'(idx_reg) : '0;
                m_sx_reg   <= '0;
                m_sy_reg   <= '0;
                m_sw_reg   <= '0;
                m_btn_reg  <= '0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {m_btn_reg, m_sw_reg, m_sy_reg, m_sx_reg, m_slot_reg};

endmodule
